[design/nv_record_list_parser_unit_defines.svh]
// assertion macros for the record list parser unit
// no dependencies; included by the modules that carry checks
`ifndef NV_RECORD_LIST_PARSER_UNIT_DEFINES_SVH
`define NV_RECORD_LIST_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define NVRL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define NVRL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define NVRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NVRL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`define NVRL_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define NVRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/nvrl_pkg.sv]
// shared types and widths for the record list parser unit
// no dependencies
`default_nettype none

package nvrl_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IDX_W      = 10;

    typedef struct packed {
        logic            core_image;
        logic [31:0]     image_size;
        logic [2:0]      backup_count;
        logic [3:0][15:0] backup_ids;
    } cfg_t;

    typedef struct packed {
        logic [15:0]      record_id;
        logic [15:0]      record_length;
        logic [31:0]      record_offset;
        logic [IDX_W-1:0] record_index;
        logic             backup_wanted;
        logic             list_end;
        logic             list_fail;
    } result_t;

endpackage

`default_nettype wire

[design/nvrl_cfg.sv]
// configuration registers of the record list parser unit
// depends on nvrl_pkg
`default_nettype none

module nvrl_cfg
    import nvrl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                       cfg
);

    localparam logic [CFG_IDX_W-1:0] REG_CORE_IMAGE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKUP_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKUP_ID_A  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACKUP_ID_B  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACKUP_ID_C  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BACKUP_ID_D  = 3'd6;

    // all zero except image_size
    localparam cfg_t CFG_RESET = cfg_t'({1'b0, 32'd65536, 3'd0, 64'd0});

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_CORE_IMAGE:   cfg_next.core_image    = cfg_wr_data[0];
                REG_IMAGE_SIZE:   cfg_next.image_size    = cfg_wr_data[31:0];
                REG_BACKUP_COUNT: cfg_next.backup_count  = cfg_wr_data[2:0];
                REG_BACKUP_ID_A:  cfg_next.backup_ids[0] = cfg_wr_data[15:0];
                REG_BACKUP_ID_B:  cfg_next.backup_ids[1] = cfg_wr_data[15:0];
                REG_BACKUP_ID_C:  cfg_next.backup_ids[2] = cfg_wr_data[15:0];
                REG_BACKUP_ID_D:  cfg_next.backup_ids[3] = cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[design/nvrl_in_stage.sv]
// input register of the record list parser unit
// depends on nvrl_pkg only for house consistency of imports
`default_nettype none

module nvrl_in_stage
    import nvrl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_image_start,
    input  wire logic       take,
    output logic            in_valid,
    output logic [7:0]      in_byte,
    output logic            in_start
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       start_reg;

    assign s_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg  <= s_data_byte;
            start_reg <= s_image_start;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_start = start_reg;

endmodule

`default_nettype wire

[design/nvrl_walker.sv]
// header walk state and per-byte decode of the record list parser unit
// depends on nvrl_pkg and nv_record_list_parser_unit_defines.svh
`default_nettype none
`include "nv_record_list_parser_unit_defines.svh"

module nvrl_walker
    import nvrl_pkg::*;
#(
    parameter int MAX_RECORDS = 1024
)
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_start,
    input  wire cfg_t       cfg,
    output result_t         res,
    output logic            res_valid
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);

    localparam logic [2:0] PH_HDR0      = 3'd0;
    localparam logic [2:0] PH_HDR1      = 3'd1;
    localparam logic [2:0] PH_HDR2      = 3'd2;
    localparam logic [2:0] PH_HDR3      = 3'd3;
    localparam logic [2:0] PH_PAYLOAD   = 3'd4;
    localparam logic [2:0] PH_STAMP     = 3'd5;
    localparam logic [2:0] PH_FAIL_NEXT = 3'd6;

    localparam logic [15:0] ID_TERM_A = 16'hFFFF;
    localparam logic [15:0] ID_TERM_B = 16'hFFFE;
    localparam logic [15:0] ID_BACKUP = 16'h0005;

    logic [31:0]      offset_reg, offset_next;
    logic [2:0]       phase_reg, phase_next;
    logic [15:0]      id_reg, id_next;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [16:0]      rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      hstart_reg, hstart_next;
    logic [33:0]      hbase_reg, hbase_next;   // header start plus 8
    logic             done_reg, done_next;

    always_comb begin
        logic [31:0]            off_e;
        logic [2:0]             phase_e;
        logic [15:0]            id_e;
        logic [7:0]             len_e;
        logic [16:0]            rem_e;
        logic [CNT_W-1:0]       cnt_e;
        logic [31:0]            hstart_e;
        logic                   done_e;
        logic [16:0]            rem_dec;
        logic [16:0]            padded;
        logic [15:0]            full_len;
        logic [CNT_W-1:0]       cnt_inc;
        logic [CNT_W+IDX_W-1:0] idx_ext;
        logic                   ends;
        logic                   match;
        logic                   fail;
        logic                   produced;

        off_e    = offset_reg;
        phase_e  = phase_reg;
        id_e     = id_reg;
        len_e    = len_lo_reg;
        rem_e    = rem_reg;
        cnt_e    = cnt_reg;
        hstart_e = hstart_reg;
        done_e   = done_reg;
        rem_dec  = '0;
        padded   = '0;
        full_len = '0;
        cnt_inc  = '0;
        idx_ext  = '0;
        ends     = 1'b0;
        match    = 1'b0;
        fail     = 1'b0;
        produced = 1'b0;
        res      = '0;

        if (in_start) begin
            off_e    = '0;
            cnt_e    = '0;
            id_e     = '0;
            len_e    = '0;
            hstart_e = '0;
            done_e   = 1'b0;
            if (cfg.core_image) begin
                rem_e   = '0;
                phase_e = PH_HDR0;
            end else begin
                rem_e   = 17'd4;
                phase_e = PH_STAMP;
            end
        end

        offset_next = off_e;
        phase_next  = phase_e;
        id_next     = id_e;
        len_lo_next = len_e;
        rem_next    = rem_e;
        cnt_next    = cnt_e;
        hstart_next = hstart_e;
        hbase_next  = hbase_reg;
        done_next   = done_e;

        // core image too small to hold even the first header
        if (in_start && cfg.core_image && (cfg.image_size < 32'd4)) begin
            fail = 1'b1;
        end else if (!done_e) begin
            offset_next = off_e + 32'd1;
            case (phase_e)
                PH_STAMP: begin
                    rem_dec  = rem_e - 17'd1;
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        phase_next = PH_HDR0;
                        if ((cnt_e >= CNT_MAX) ||
                            (({1'b0, off_e} + 33'd5) > {1'b0, cfg.image_size})) begin
                            fail = 1'b1;
                        end
                    end
                end
                PH_HDR0: begin
                    hstart_next = off_e;
                    hbase_next  = {2'b00, off_e} + 34'd8;
                    id_next     = {8'h00, in_byte};
                    phase_next  = PH_HDR1;
                end
                PH_HDR1: begin
                    id_next    = {in_byte, id_e[7:0]};
                    phase_next = PH_HDR2;
                end
                PH_HDR2: begin
                    len_lo_next = in_byte;
                    phase_next  = PH_HDR3;
                end
                PH_HDR3: begin
                    full_len = {in_byte, len_e};
                    cnt_inc  = cnt_e + 1'b1;
                    cnt_next = cnt_inc;
                    idx_ext  = {{IDX_W{1'b0}}, cnt_e};
                    ends     = (id_e == ID_TERM_A) || (id_e == ID_TERM_B) ||
                               (({1'b0, hstart_e} + 33'd4) == {1'b0, cfg.image_size});
                    match    = (id_e == ID_BACKUP);
                    for (int k = 0; k < 4; k++) begin
                        if ((cfg.backup_count > 3'(k)) && (cfg.backup_ids[k] == id_e)) begin
                            match = 1'b1;
                        end
                    end
                    produced          = 1'b1;
                    res.record_id     = id_e;
                    res.record_length = full_len;
                    res.record_offset = hstart_e;
                    res.record_index  = idx_ext[IDX_W-1:0];
                    res.backup_wanted = match;
                    res.list_end      = ends;
                    if (ends) begin
                        done_next = 1'b1;
                    end else begin
                        padded = ({1'b0, full_len} + 17'd3) & ~17'd3;
                        if ((cnt_inc >= CNT_MAX) ||
                            ((hbase_reg + {17'd0, padded}) > {2'b00, cfg.image_size})) begin
                            phase_next = PH_FAIL_NEXT;
                        end else if (padded == '0) begin
                            phase_next = PH_HDR0;
                        end else begin
                            rem_next   = padded;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    rem_dec  = rem_e - 17'd1;
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        phase_next = PH_HDR0;
                    end
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
        end

        if (fail) begin
            res           = '0;
            res.list_fail = 1'b1;
            produced      = 1'b1;
            done_next     = 1'b1;
        end

        res_valid = step && produced;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            phase_reg  <= PH_HDR0;
            id_reg     <= '0;
            len_lo_reg <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            hstart_reg <= '0;
            hbase_reg  <= '0;
            done_reg   <= 1'b1;
        end else if (step) begin
            offset_reg <= offset_next;
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            len_lo_reg <= len_lo_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            hstart_reg <= hstart_next;
            hbase_reg  <= hbase_next;
            done_reg   <= done_next;
        end
    end

    `NVRL_ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_MAX, "record count past limit")

    `NVRL_ASSERT_IMPLY(a_payload_rem, aclk, aresetn, !done_reg && (phase_reg == PH_PAYLOAD), rem_reg != '0, "payload skip with nothing left")

    `NVRL_ASSERT_NEXT(a_stop_after_end, aclk, aresetn, res_valid && (res.list_end || res.list_fail), done_reg, "walk did not stop after final transaction")

endmodule

`default_nettype wire

[design/nvrl_out_stage.sv]
// result register of the record list parser unit
// depends on nvrl_pkg
`default_nettype none

module nvrl_out_stage
    import nvrl_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t res,
    output logic         can_accept,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_res
);

    logic    valid_reg;
    result_t data_reg;

    assign can_accept = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = data_reg;

endmodule

`default_nettype wire

[design/nv_record_list_parser_unit.sv]
// Record list parser. Bytes of a parameter image enter on the s_ channel, one per
// transaction; s_image_start marks byte 0 and restarts the walk. A plain image
// skips a 4-byte stamp first. Every 4-byte header (id, length, little-endian)
// gives one m_ transaction with id, raw length, offset, ordinal and backup flag;
// payloads are skipped with 4-byte padding. list_end marks a terminator id or a
// header that ends at image_size; list_fail marks an image that ran out or hit
// the record limit, with all record fields zero.
// A header's result is decoded from its last byte in the input register and loaded
// into the result register. Throughput: one byte per cycle while the result register
// can accept, set by the single decode step between the input and result registers.
// While the result register holds a transaction and m_ready is low, it keeps it and
// no byte is decoded; the input register takes a byte only if it is empty, and s_ready
// stays low until the result moves.
// Reset clears both registers and leaves the walk idle: bytes are dropped until
// one arrives with s_image_start set. The config port writes one register per
// cycle with cfg_wr_en and is meant to be used only while no walk is pending.
// depends on nvrl_pkg, nvrl_cfg, nvrl_in_stage, nvrl_walker, nvrl_out_stage
`default_nettype none
`include "nv_record_list_parser_unit_defines.svh"

module nv_record_list_parser_unit
    import nvrl_pkg::*;
#(
    parameter int MAX_RECORDS = 1024
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_data_byte,
    input  wire logic                  s_image_start,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [15:0]                m_record_id,
    output logic [15:0]                m_record_length,
    output logic [31:0]                m_record_offset,
    output logic [IDX_W-1:0]           m_record_index,
    output logic                       m_backup_wanted,
    output logic                       m_list_end,
    output logic                       m_list_fail
);

    cfg_t       cfg;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_start;
    logic       can_accept;
    logic       step;
    result_t    res;
    logic       res_valid;
    result_t    m_res;

    assign step = in_valid && can_accept;

    nvrl_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    nvrl_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_image_start (s_image_start),
        .take          (step),
        .in_valid      (in_valid),
        .in_byte       (in_byte),
        .in_start      (in_start)
    );

    nvrl_walker #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .in_byte   (in_byte),
        .in_start  (in_start),
        .cfg       (cfg),
        .res       (res),
        .res_valid (res_valid)
    );

    nvrl_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (res_valid),
        .res        (res),
        .can_accept (can_accept),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    assign m_record_id     = m_res.record_id;
    assign m_record_length = m_res.record_length;
    assign m_record_offset = m_res.record_offset;
    assign m_record_index  = m_res.record_index;
    assign m_backup_wanted = m_res.backup_wanted;
    assign m_list_end      = m_res.list_end;
    assign m_list_fail     = m_res.list_fail;

    // input side only stalls behind a held result
    `NVRL_ASSERT_IMPLY(a_stall_cause, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without a held result")

endmodule

`default_nettype wire
